// ----- rtl/dap_pkg.sv -----
// ----------------------------------------------------------------------------
// dap_pkg
// Shared widths, constants and types for the distance attenuate and pan block.
// ----------------------------------------------------------------------------
package dap_pkg;

    localparam int DEF_SAMPLE_BITS     = 16;
    localparam int DEF_COORD_FRAC_BITS = 16;

    localparam int COORD_W   = 32;
    localparam int EAR_W     = 16;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int SQ_W      = 2 * DIFF_W;
    localparam int DP_W      = DIFF_W + EAR_W;
    localparam int DOT_W     = DP_W + 2;
    localparam int DMAG_W    = DOT_W - 1;
    localparam int D2_W      = 64;
    localparam int LEN_W     = 32;
    localparam int DIV_W     = LEN_W + 2;
    localparam int ATT_W     = 31;
    localparam int RQ_W      = 30;
    localparam int GAIN_W    = 16;
    localparam int ROOT_STEPS  = 32;
    localparam int RECIP_STEPS = 30;
    localparam int DIV_STEPS   = 15;

    localparam logic [ATT_W-1:0]  ATT_ONE = ATT_W'(1) << 30;
    localparam logic [GAIN_W-1:0] C_ONE   = GAIN_W'(16384);

    // Side information that rides along the root and divide sections
    typedef struct packed {
        logic              zero;   // source at the receiver: mute
        logic              near;   // d2 within unit distance: full gain
        logic              dneg;   // sign of the dot product
        logic [DMAG_W-1:0] dmag;   // magnitude of the dot product
    } side_t;

endpackage

// ----- rtl/distance_attenuate_and_pan.sv -----
// ----------------------------------------------------------------------------
// distance_attenuate_and_pan
// Inverse-square distance attenuation with stereo pan, fully pipelined.
// ----------------------------------------------------------------------------
// Takes one request per cycle while the output is not stalled. Pipeline:
// 4 stages form the offset vector, squared distance and dot product, 32
// stages take the square root one bit at a time (the 30-bit reciprocal for
// the attenuation runs in the first 30 of them), 17 stages divide out the pan
// cosine and form the gains, and 3 stages scale the samples. A stall on the
// output holds every stage at once and is passed straight back to in_stall
// whenever the output register is full.
module distance_attenuate_and_pan import dap_pkg::*;
#(
    parameter int SAMPLE_BITS     = DEF_SAMPLE_BITS,
    parameter int COORD_FRAC_BITS = DEF_COORD_FRAC_BITS
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [SAMPLE_BITS-1:0] left_sample,
    input  logic signed [SAMPLE_BITS-1:0] right_sample,
    input  logic signed [COORD_W-1:0]     source_x,
    input  logic signed [COORD_W-1:0]     source_y,
    input  logic signed [COORD_W-1:0]     source_z,
    input  logic signed [COORD_W-1:0]     listener_x,
    input  logic signed [COORD_W-1:0]     listener_y,
    input  logic signed [COORD_W-1:0]     listener_z,
    input  logic signed [EAR_W-1:0]       ear_dir_x,
    input  logic signed [EAR_W-1:0]       ear_dir_y,
    input  logic signed [EAR_W-1:0]       ear_dir_z,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [SAMPLE_BITS-1:0] left_out,
    output logic signed [SAMPLE_BITS-1:0] right_out
);

    logic adv;
    logic signed [COORD_W-1:0] src [3];
    logic signed [COORD_W-1:0] lst [3];
    logic signed [EAR_W-1:0]   ear [3];

    logic                          f_vld, r_vld, d_vld;
    logic signed [SAMPLE_BITS-1:0] f_ls, f_rs, r_ls, r_rs, d_ls, d_rs;
    logic [D2_W-1:0]               f_d2;
    side_t                         f_side, r_side;
    logic [LEN_W-1:0]              r_len;
    logic [ATT_W-1:0]              r_att, d_att;
    logic [GAIN_W-1:0]             d_gl, d_gr;

    assign adv      = !(out_valid && out_stall);
    assign in_stall = !adv;

    assign src[0] = source_x;
    assign src[1] = source_y;
    assign src[2] = source_z;
    assign lst[0] = listener_x;
    assign lst[1] = listener_y;
    assign lst[2] = listener_z;
    assign ear[0] = ear_dir_x;
    assign ear[1] = ear_dir_y;
    assign ear[2] = ear_dir_z;

    dap_front #(
        .SAMPLE_BITS     (SAMPLE_BITS),
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .adv    (adv),
        .vld_i  (in_valid),
        .ls_i   (left_sample),
        .rs_i   (right_sample),
        .src_i  (src),
        .lst_i  (lst),
        .ear_i  (ear),
        .vld_o  (f_vld),
        .ls_o   (f_ls),
        .rs_o   (f_rs),
        .d2_o   (f_d2),
        .side_o (f_side)
    );

    dap_root #(
        .SAMPLE_BITS     (SAMPLE_BITS),
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_root (
        .clk    (clk),
        .rst_n  (rst_n),
        .adv    (adv),
        .vld_i  (f_vld),
        .ls_i   (f_ls),
        .rs_i   (f_rs),
        .d2_i   (f_d2),
        .side_i (f_side),
        .vld_o  (r_vld),
        .ls_o   (r_ls),
        .rs_o   (r_rs),
        .len_o  (r_len),
        .att_o  (r_att),
        .side_o (r_side)
    );

    dap_div #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .adv    (adv),
        .vld_i  (r_vld),
        .ls_i   (r_ls),
        .rs_i   (r_rs),
        .len_i  (r_len),
        .att_i  (r_att),
        .side_i (r_side),
        .vld_o  (d_vld),
        .ls_o   (d_ls),
        .rs_o   (d_rs),
        .att_o  (d_att),
        .gl_o   (d_gl),
        .gr_o   (d_gr)
    );

    dap_scale #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_scale (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (adv),
        .vld_i (d_vld),
        .ls_i  (d_ls),
        .rs_i  (d_rs),
        .att_i (d_att),
        .gl_i  (d_gl),
        .gr_i  (d_gr),
        .vld_o (out_valid),
        .lo_o  (left_out),
        .ro_o  (right_out)
    );

endmodule

// ----- rtl/dap_front.sv -----
// ----------------------------------------------------------------------------
// dap_front
// Offset vector, squared distance and dot product with the ear direction.
// Four register stages.
// ----------------------------------------------------------------------------
module dap_front import dap_pkg::*;
#(
    parameter int SAMPLE_BITS     = DEF_SAMPLE_BITS,
    parameter int COORD_FRAC_BITS = DEF_COORD_FRAC_BITS
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic                          vld_i,
    input  logic signed [SAMPLE_BITS-1:0] ls_i,
    input  logic signed [SAMPLE_BITS-1:0] rs_i,
    input  logic signed [COORD_W-1:0]     src_i [3],
    input  logic signed [COORD_W-1:0]     lst_i [3],
    input  logic signed [EAR_W-1:0]       ear_i [3],
    output logic                          vld_o,
    output logic signed [SAMPLE_BITS-1:0] ls_o,
    output logic signed [SAMPLE_BITS-1:0] rs_o,
    output logic [D2_W-1:0]               d2_o,
    output side_t                         side_o
);

    localparam logic [D2_W-1:0] D2_ONE = D2_W'(1) << (2 * COORD_FRAC_BITS - 2);
    localparam logic [D2_W-1:0] D2_EPS = (D2_ONE + D2_W'(500000)) / D2_W'(1000000);

    logic [3:0]                    v_reg;
    logic signed [SAMPLE_BITS-1:0] ls_reg [4];
    logic signed [SAMPLE_BITS-1:0] rs_reg [4];
    logic signed [DIFF_W-1:0]      d1_reg [3];
    logic signed [EAR_W-1:0]       e1_reg [3];
    logic signed [SQ_W-1:0]        sq2_reg [3];
    logic signed [DP_W-1:0]        dp2_reg [3];
    logic [SQ_W-1:0]               sum3_reg;
    logic signed [DOT_W-1:0]       dot3_reg;
    logic [D2_W-1:0]               d2_reg;
    side_t                         side_reg;
    logic [D2_W-1:0]               d2_next;
    logic [DOT_W-1:0]              dneg_val;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[2:0], vld_i};
        end
    end

    assign d2_next  = sum3_reg[SQ_W-1:2];
    assign dneg_val = DOT_W'(0) - DOT_W'(dot3_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ls_reg[0] <= ls_i;
            rs_reg[0] <= rs_i;
            for (int i = 1; i < 4; i++)
            begin
                ls_reg[i] <= ls_reg[i-1];
                rs_reg[i] <= rs_reg[i-1];
            end
            for (int i = 0; i < 3; i++)
            begin
                d1_reg[i]  <= DIFF_W'(src_i[i]) - DIFF_W'(lst_i[i]);
                e1_reg[i]  <= ear_i[i];
                sq2_reg[i] <= d1_reg[i] * d1_reg[i];
                dp2_reg[i] <= d1_reg[i] * e1_reg[i];
            end
            sum3_reg <= SQ_W'(sq2_reg[0]) + SQ_W'(sq2_reg[1]) + SQ_W'(sq2_reg[2]);
            dot3_reg <= DOT_W'(dp2_reg[0]) + DOT_W'(dp2_reg[1]) + DOT_W'(dp2_reg[2]);
            d2_reg        <= d2_next;
            side_reg.zero <= (d2_next <= D2_EPS);
            side_reg.near <= (d2_next <= D2_ONE);
            side_reg.dneg <= dot3_reg[DOT_W-1];
            side_reg.dmag <= dot3_reg[DOT_W-1] ? dneg_val[DMAG_W-1:0]
                                               : dot3_reg[DMAG_W-1:0];
        end
    end

    assign vld_o  = v_reg[3];
    assign ls_o   = ls_reg[3];
    assign rs_o   = rs_reg[3];
    assign d2_o   = d2_reg;
    assign side_o = side_reg;

endmodule

// ----- rtl/dap_root.sv -----
// ----------------------------------------------------------------------------
// dap_root
// Pipelined square root of d2 (one result bit per stage) with the Q.30
// reciprocal of d2 formed over the first RECIP_STEPS stages, a bit each.
// ----------------------------------------------------------------------------
module dap_root import dap_pkg::*;
#(
    parameter int SAMPLE_BITS     = DEF_SAMPLE_BITS,
    parameter int COORD_FRAC_BITS = DEF_COORD_FRAC_BITS
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic                          vld_i,
    input  logic signed [SAMPLE_BITS-1:0] ls_i,
    input  logic signed [SAMPLE_BITS-1:0] rs_i,
    input  logic [D2_W-1:0]               d2_i,
    input  side_t                         side_i,
    output logic                          vld_o,
    output logic signed [SAMPLE_BITS-1:0] ls_o,
    output logic signed [SAMPLE_BITS-1:0] rs_o,
    output logic [LEN_W-1:0]              len_o,
    output logic [ATT_W-1:0]              att_o,
    output side_t                         side_o
);

    localparam logic [D2_W-1:0] D2_ONE = D2_W'(1) << (2 * COORD_FRAC_BITS - 2);

    logic                          v   [ROOT_STEPS+1];
    logic signed [SAMPLE_BITS-1:0] ls  [ROOT_STEPS+1];
    logic signed [SAMPLE_BITS-1:0] rs  [ROOT_STEPS+1];
    logic [D2_W-1:0]               x   [ROOT_STEPS+1];
    logic [D2_W-1:0]               r   [ROOT_STEPS+1];
    logic [D2_W-1:0]               dd  [ROOT_STEPS+1];
    logic [D2_W-1:0]               rm  [ROOT_STEPS+1];
    logic [RQ_W-1:0]               q   [ROOT_STEPS+1];
    side_t                         sd  [ROOT_STEPS+1];

    assign v[0]  = vld_i;
    assign ls[0] = ls_i;
    assign rs[0] = rs_i;
    assign x[0]  = d2_i;
    assign r[0]  = '0;
    assign dd[0] = d2_i;
    assign rm[0] = D2_ONE;
    assign q[0]  = '0;
    assign sd[0] = side_i;

    for (genvar k = 0; k < ROOT_STEPS; k++)
    begin : g_step
        localparam logic [D2_W-1:0] BIT = D2_W'(1) << (62 - 2 * k);
        logic [D2_W-1:0] t;
        logic            ge;
        logic [D2_W:0]   sh;
        logic            ge2;
        logic            v_reg;
        logic [D2_W-1:0] x_reg, r_reg, dd_reg, rm_reg;
        logic [RQ_W-1:0] q_reg;
        logic signed [SAMPLE_BITS-1:0] ls_reg, rs_reg;
        side_t           sd_reg;

        assign t   = r[k] + BIT;
        assign ge  = (x[k] >= t);
        assign sh  = {rm[k], 1'b0};
        assign ge2 = (sh >= {1'b0, dd[k]});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg <= 1'b0;
            end
            else if (adv)
            begin
                v_reg <= v[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                ls_reg <= ls[k];
                rs_reg <= rs[k];
                sd_reg <= sd[k];
                dd_reg <= dd[k];
                x_reg  <= ge ? (x[k] - t) : x[k];
                r_reg  <= ge ? ((r[k] >> 1) + BIT) : (r[k] >> 1);
                if (k < RECIP_STEPS)
                begin
                    rm_reg <= ge2 ? D2_W'(sh - {1'b0, dd[k]}) : sh[D2_W-1:0];
                    q_reg  <= {q[k][RQ_W-2:0], ge2};
                end
                else
                begin
                    rm_reg <= rm[k];
                    q_reg  <= q[k];
                end
            end
        end

        assign v[k+1]  = v_reg;
        assign ls[k+1] = ls_reg;
        assign rs[k+1] = rs_reg;
        assign x[k+1]  = x_reg;
        assign r[k+1]  = r_reg;
        assign dd[k+1] = dd_reg;
        assign rm[k+1] = rm_reg;
        assign q[k+1]  = q_reg;
        assign sd[k+1] = sd_reg;
    end

    assign vld_o  = v[ROOT_STEPS];
    assign ls_o   = ls[ROOT_STEPS];
    assign rs_o   = rs[ROOT_STEPS];
    assign len_o  = r[ROOT_STEPS][LEN_W-1:0];
    assign side_o = sd[ROOT_STEPS];
    assign att_o  = sd[ROOT_STEPS].zero ? '0 :
                    sd[ROOT_STEPS].near ? ATT_ONE : {1'b0, q[ROOT_STEPS]};

endmodule

// ----- rtl/dap_div.sv -----
// ----------------------------------------------------------------------------
// dap_div
// Pan cosine |dot| / (2 len), one quotient bit per stage, clamped to one,
// then registered left and right pan gains.
// ----------------------------------------------------------------------------
module dap_div import dap_pkg::*;
#(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic                          vld_i,
    input  logic signed [SAMPLE_BITS-1:0] ls_i,
    input  logic signed [SAMPLE_BITS-1:0] rs_i,
    input  logic [LEN_W-1:0]              len_i,
    input  logic [ATT_W-1:0]              att_i,
    input  side_t                         side_i,
    output logic                          vld_o,
    output logic signed [SAMPLE_BITS-1:0] ls_o,
    output logic signed [SAMPLE_BITS-1:0] rs_o,
    output logic [ATT_W-1:0]              att_o,
    output logic [GAIN_W-1:0]             gl_o,
    output logic [GAIN_W-1:0]             gr_o
);

    logic                          v   [DIV_STEPS+1];
    logic signed [SAMPLE_BITS-1:0] ls  [DIV_STEPS+1];
    logic signed [SAMPLE_BITS-1:0] rs  [DIV_STEPS+1];
    logic [ATT_W-1:0]              at  [DIV_STEPS+1];
    logic [DMAG_W-1:0]             rem [DIV_STEPS+1];
    logic [DIV_W-1:0]              dv  [DIV_STEPS+1];
    logic [DIV_STEPS-1:0]          q   [DIV_STEPS+1];
    logic                          ovf [DIV_STEPS+1];
    logic                          ng  [DIV_STEPS+1];

    logic                          v0_reg, vg_reg;
    logic signed [SAMPLE_BITS-1:0] ls0_reg, rs0_reg, lsg_reg, rsg_reg;
    logic [ATT_W-1:0]              at0_reg, atg_reg;
    logic [DMAG_W-1:0]             rem0_reg;
    logic [DIV_W-1:0]              dv0_reg;
    logic                          ovf0_reg, ng0_reg;
    logic [GAIN_W-1:0]             gl_reg, gr_reg;
    logic [DIV_W-1:0]              dv_in;
    logic [GAIN_W-1:0]             cm;

    assign dv_in = {1'b0, len_i, 1'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            vg_reg <= 1'b0;
        end
        else if (adv)
        begin
            v0_reg <= vld_i;
            vg_reg <= v[DIV_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ls0_reg  <= ls_i;
            rs0_reg  <= rs_i;
            at0_reg  <= att_i;
            rem0_reg <= side_i.dmag;
            dv0_reg  <= dv_in;
            ng0_reg  <= side_i.dneg;
            // quotient of 2^15 or more clamps regardless of the low bits
            ovf0_reg <= (side_i.dmag >= (DMAG_W'(dv_in) << DIV_STEPS));
        end
    end

    assign v[0]   = v0_reg;
    assign ls[0]  = ls0_reg;
    assign rs[0]  = rs0_reg;
    assign at[0]  = at0_reg;
    assign rem[0] = rem0_reg;
    assign dv[0]  = dv0_reg;
    assign q[0]   = '0;
    assign ovf[0] = ovf0_reg;
    assign ng[0]  = ng0_reg;

    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_step
        localparam int J = DIV_STEPS - 1 - k;
        logic [DMAG_W-1:0]             sub;
        logic                          ge;
        logic                          v_reg;
        logic signed [SAMPLE_BITS-1:0] ls_reg, rs_reg;
        logic [ATT_W-1:0]              at_reg;
        logic [DMAG_W-1:0]             rem_reg;
        logic [DIV_W-1:0]              dv_reg;
        logic [DIV_STEPS-1:0]          q_reg;
        logic                          ovf_reg, ng_reg;

        assign sub = DMAG_W'(dv[k]) << J;
        assign ge  = (rem[k] >= sub);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg <= 1'b0;
            end
            else if (adv)
            begin
                v_reg <= v[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                ls_reg  <= ls[k];
                rs_reg  <= rs[k];
                at_reg  <= at[k];
                dv_reg  <= dv[k];
                ovf_reg <= ovf[k];
                ng_reg  <= ng[k];
                rem_reg <= ge ? (rem[k] - sub) : rem[k];
                q_reg   <= q[k] | (DIV_STEPS'(ge) << J);
            end
        end

        assign v[k+1]   = v_reg;
        assign ls[k+1]  = ls_reg;
        assign rs[k+1]  = rs_reg;
        assign at[k+1]  = at_reg;
        assign rem[k+1] = rem_reg;
        assign dv[k+1]  = dv_reg;
        assign q[k+1]   = q_reg;
        assign ovf[k+1] = ovf_reg;
        assign ng[k+1]  = ng_reg;
    end

    assign cm = (ovf[DIV_STEPS] || (GAIN_W'(q[DIV_STEPS]) > C_ONE)) ? C_ONE
                                                                   : GAIN_W'(q[DIV_STEPS]);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lsg_reg <= ls[DIV_STEPS];
            rsg_reg <= rs[DIV_STEPS];
            atg_reg <= at[DIV_STEPS];
            gl_reg  <= ng[DIV_STEPS] ? (C_ONE - cm) : (C_ONE + cm);
            gr_reg  <= ng[DIV_STEPS] ? (C_ONE + cm) : (C_ONE - cm);
        end
    end

    assign vld_o = vg_reg;
    assign ls_o  = lsg_reg;
    assign rs_o  = rsg_reg;
    assign att_o = atg_reg;
    assign gl_o  = gl_reg;
    assign gr_o  = gr_reg;

endmodule

// ----- rtl/dap_scale.sv -----
// ----------------------------------------------------------------------------
// dap_scale
// Combines attenuation with the pan gains and scales both samples with
// round to nearest, ties away from zero. Three register stages.
// ----------------------------------------------------------------------------
module dap_scale import dap_pkg::*;
#(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic                          vld_i,
    input  logic signed [SAMPLE_BITS-1:0] ls_i,
    input  logic signed [SAMPLE_BITS-1:0] rs_i,
    input  logic [ATT_W-1:0]              att_i,
    input  logic [GAIN_W-1:0]             gl_i,
    input  logic [GAIN_W-1:0]             gr_i,
    output logic                          vld_o,
    output logic signed [SAMPLE_BITS-1:0] lo_o,
    output logic signed [SAMPLE_BITS-1:0] ro_o
);

    localparam int PW = SAMPLE_BITS + ATT_W;
    localparam logic [PW-1:0] HALF = PW'(1) << 29;

    logic [2:0]             v_reg;
    logic [ATT_W-1:0]       gl_reg, gr_reg;
    logic [SAMPLE_BITS-1:0] ml_reg, mr_reg;
    logic                   nl_reg, nr_reg, nl2_reg, nr2_reg;
    logic [PW-1:0]          pl_reg, pr_reg;
    logic [PW-1:0]          sl, sr;
    logic [SAMPLE_BITS-1:0] ul, ur;
    logic signed [SAMPLE_BITS-1:0] lo_reg, ro_reg;
    logic [ATT_W+GAIN_W-1:0] ml_prod, mr_prod;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[1:0], vld_i};
        end
    end

    assign ml_prod = (ATT_W+GAIN_W)'(att_i) * (ATT_W+GAIN_W)'(gl_i);
    assign mr_prod = (ATT_W+GAIN_W)'(att_i) * (ATT_W+GAIN_W)'(gr_i);
    assign sl = pl_reg + HALF;
    assign sr = pr_reg + HALF;
    assign ul = sl[SAMPLE_BITS+29:30];
    assign ur = sr[SAMPLE_BITS+29:30];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            gl_reg  <= ml_prod[ATT_W+14:15];
            gr_reg  <= mr_prod[ATT_W+14:15];
            ml_reg  <= ls_i[SAMPLE_BITS-1] ? (SAMPLE_BITS'(0) - ls_i) : ls_i;
            mr_reg  <= rs_i[SAMPLE_BITS-1] ? (SAMPLE_BITS'(0) - rs_i) : rs_i;
            nl_reg  <= ls_i[SAMPLE_BITS-1];
            nr_reg  <= rs_i[SAMPLE_BITS-1];
            pl_reg  <= PW'(ml_reg) * PW'(gl_reg);
            pr_reg  <= PW'(mr_reg) * PW'(gr_reg);
            nl2_reg <= nl_reg;
            nr2_reg <= nr_reg;
            lo_reg  <= nl2_reg ? (SAMPLE_BITS'(0) - ul) : ul;
            ro_reg  <= nr2_reg ? (SAMPLE_BITS'(0) - ur) : ur;
        end
    end

    assign vld_o = v_reg[2];
    assign lo_o  = lo_reg;
    assign ro_o  = ro_reg;

endmodule

// ----- rtl/dap_checker.sv -----
// ----------------------------------------------------------------------------
// dap_checker
// Port-level checks on the distance attenuate and pan block.
// ----------------------------------------------------------------------------
module dap_checker import dap_pkg::*;
#(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
)
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic signed [SAMPLE_BITS-1:0] left_out,
    input logic signed [SAMPLE_BITS-1:0] right_out
);

    // held result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(left_out) && $stable(right_out))
        else $error("result changed while stalled");

    // the pipeline only pushes back when a finished result is blocked
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a blocked result");

    a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_stall |-> !in_stall)
        else $error("input stalled while output is free");

endmodule

bind distance_attenuate_and_pan dap_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_dap_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .left_out  (left_out),
    .right_out (right_out)
);

// ----- tb/sv/tb_distance_attenuate_and_pan.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_distance_attenuate_and_pan
// Drives random and corner-case sample/position requests through the block,
// predicts each attenuated, panned output pair and checks it in order.
// ----------------------------------------------------------------------------
module tb_distance_attenuate_and_pan;
    import dap_pkg::*;

    localparam int SB = 16;
    localparam int NUM_RANDOM = 1400;
    localparam int LATENCY = 56;

    typedef struct {
        logic signed [SB-1:0]      ls;
        logic signed [SB-1:0]      rs;
        logic signed [COORD_W-1:0] sx, sy, sz;
        logic signed [COORD_W-1:0] lx, ly, lz;
        logic signed [EAR_W-1:0]   ex, ey, ez;
    } request_t;

    typedef struct {
        logic signed [SB-1:0] lo;
        logic signed [SB-1:0] ro;
    } pair_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [SB-1:0] left_sample = '0, right_sample = '0;
    logic signed [COORD_W-1:0] source_x = '0, source_y = '0, source_z = '0;
    logic signed [COORD_W-1:0] listener_x = '0, listener_y = '0, listener_z = '0;
    logic signed [EAR_W-1:0] ear_dir_x = '0, ear_dir_y = '0, ear_dir_z = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [SB-1:0] left_out, right_out;

    request_t pending_q[$];
    pair_t    expected_pairs[$];
    int       mismatches = 0;
    bit       fill_done = 0;
    bit       quiet_tail = 0;
    int       send_gap = 0, recv_gap = 0;

    distance_attenuate_and_pan i_dut (.*);

    always #1 clk = ~clk;

    // d2 in Q.30 form as the block reckons it (fits in 64 bits unsigned)
    function automatic pair_t predict_pan(request_t r);
        logic signed [33:0] d[3];
        logic signed [15:0] e[3];
        logic [66:0] sum;
        logic [63:0] d2, att, len, cm, gl, gr, rem, q, bitv, x, dmag;
        logic signed [63:0] dot, c;
        logic [64:0] rem2;
        pair_t p;
        d[0] = 34'(r.sx) - 34'(r.lx);
        d[1] = 34'(r.sy) - 34'(r.ly);
        d[2] = 34'(r.sz) - 34'(r.lz);
        e[0] = r.ex; e[1] = r.ey; e[2] = r.ez;
        sum = '0;
        dot = 0;
        for (int i = 0; i < 3; i++)
        begin
            sum += 67'(d[i] * d[i]);
            dot += 64'(d[i]) * 64'(e[i]);
        end
        d2 = 64'(sum >> 2);
        if (d2 <= 64'd1074)
        begin
            p.lo = '0; p.ro = '0;
            return p;
        end
        if (d2 <= (64'd1 << 30))
            att = 64'd1 << 30;
        else
        begin
            rem = 64'd1 << 30;
            q = 0;
            for (int i = 0; i < 30; i++)
            begin
                rem2 = {rem, 1'b0};
                q = q << 1;
                if (rem2 >= {1'b0, d2})
                begin
                    rem2 = rem2 - {1'b0, d2};
                    q[0] = 1'b1;
                end
                rem = rem2[63:0];
            end
            att = q;
        end
        x = d2; len = 0; bitv = 64'd1 << 62;
        while (bitv > x) bitv >>= 2;
        while (bitv != 0)
        begin
            if (x >= len + bitv)
            begin
                x -= len + bitv;
                len = (len >> 1) + bitv;
            end
            else
                len >>= 1;
            bitv >>= 2;
        end
        dmag = dot < 0 ? 64'(-dot) : 64'(dot);
        cm = dmag / (2 * len);
        if (cm > 16384) cm = 16384;
        c = dot < 0 ? -$signed(cm) : $signed(cm);
        gl = (att * 64'(16384 + c)) >> 15;
        gr = (att * 64'(16384 - c)) >> 15;
        p.lo = scale(r.ls, gl);
        p.ro = scale(r.rs, gr);
        return p;
    endfunction

    function automatic logic signed [SB-1:0] scale(logic signed [SB-1:0] s, logic [63:0] g);
        logic [63:0] m;
        m = s < 0 ? 64'(-64'(s)) : 64'(s);
        m = (m * g + (64'd1 << 29)) >> 30;
        return s < 0 ? SB'(-m) : SB'(m);
    endfunction

    function automatic logic signed [COORD_W-1:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            2: return 32'($signed($urandom_range(0, 20'hfffff)) - 32'h80000);
            default: return 32'($signed($urandom_range(0, 24'hffffff)) - 32'h800000);
        endcase
    endfunction

    function automatic logic signed [EAR_W-1:0] rand_ear();
        if ($urandom_range(0, 7) == 0)
            return EAR_W'($urandom);
        return 16'($signed($urandom_range(0, 32768)) - 16384);
    endfunction

    function automatic request_t rand_request();
        request_t r;
        r.ls = SB'($urandom); r.rs = SB'($urandom);
        r.lx = rand_coord(); r.ly = rand_coord(); r.lz = rand_coord();
        r.ex = rand_ear(); r.ey = rand_ear(); r.ez = rand_ear();
        case ($urandom_range(0, 9))
            0:
            begin
                // source near or at the receiver
                r.sx = r.lx + 32'($signed($urandom_range(0, 130)) - 65);
                r.sy = r.ly; r.sz = r.lz;
            end
            1:
            begin
                r.sx = r.lx + 32'($signed($urandom_range(0, 131072)) - 65536);
                r.sy = r.ly + 32'($signed($urandom_range(0, 131072)) - 65536);
                r.sz = r.lz;
            end
            default:
            begin
                r.sx = rand_coord(); r.sy = rand_coord(); r.sz = rand_coord();
            end
        endcase
        return r;
    endfunction

    function automatic request_t make_req(logic signed [SB-1:0] ls, logic signed [SB-1:0] rs,
        logic signed [31:0] sx, logic signed [31:0] lx, logic signed [15:0] ex);
        request_t r;
        r.ls = ls; r.rs = rs;
        r.sx = sx; r.sy = 0; r.sz = 0;
        r.lx = lx; r.ly = 0; r.lz = 0;
        r.ex = ex; r.ey = 0; r.ez = 0;
        return r;
    endfunction

    initial
    begin
        request_t r;
        // directed corners
        pending_q.push_back(make_req(16'sh7fff, 16'sh8000, 0, 0, 16384));
        pending_q.push_back(make_req(16'sh7fff, 16'sh8000, 1, 0, 16384));
        pending_q.push_back(make_req(16'sh7fff, 16'sh8000, 32'h10000, 0, 16384));
        pending_q.push_back(make_req(16'sh7fff, 16'sh8000, 32'h10000, 0, -16384));
        pending_q.push_back(make_req(16'sh8000, 16'sh7fff, -32'h8000, 0, 16384));
        pending_q.push_back(make_req(16'sh8000, 16'sh7fff, 32'h20000, 0, 0));
        pending_q.push_back(make_req(16'sh7fff, 16'sh7fff, 32'h7fffffff, 32'h80000000, 16384));
        pending_q.push_back(make_req(16'sh8000, 16'sh8000, 32'h80000000, 32'h7fffffff, -16384));
        pending_q.push_back(make_req(-1, 1, 32'h30000, 0, 16'sh7fff));
        pending_q.push_back(make_req(12345, -12345, 32'h30000, 0, 16'sh8000));
        pending_q.push_back(make_req(16'sh7fff, 16'sh8000, 1100, 0, 16384));
        r = make_req(16'sh7fff, 16'sh8000, 32'h7fffffff, 32'h80000000, 16384);
        r.sy = 32'h7fffffff; r.ly = 32'h80000000; r.sz = 32'h80000000; r.lz = 32'h7fffffff;
        r.ey = 16384; r.ez = -16384;
        pending_q.push_back(r);
        r.ex = 16'sh7fff; r.ey = 16'sh7fff; r.ez = 16'sh8000;
        pending_q.push_back(r);
        for (int i = 0; i < NUM_RANDOM; i++)
            pending_q.push_back(rand_request());
        fill_done = 1;
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    // driver
    always @(posedge clk)
    begin
        request_t r;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                r.ls = left_sample; r.rs = right_sample;
                r.sx = source_x; r.sy = source_y; r.sz = source_z;
                r.lx = listener_x; r.ly = listener_y; r.lz = listener_z;
                r.ex = ear_dir_x; r.ey = ear_dir_y; r.ez = ear_dir_z;
                expected_pairs.push_back(predict_pan(r));
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_q.size() < 200)
                    quiet_tail = 1;
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (!quiet_tail && $urandom_range(0, 15) == 0)
                begin
                    send_gap = $urandom_range(0, 11);
                    in_valid <= 1'b0;
                end
                else if (pending_q.size() > 0)
                begin
                    r = pending_q.pop_front();
                    in_valid <= 1'b1;
                    left_sample <= r.ls; right_sample <= r.rs;
                    source_x <= r.sx; source_y <= r.sy; source_z <= r.sz;
                    listener_x <= r.lx; listener_y <= r.ly; listener_z <= r.lz;
                    ear_dir_x <= r.ex; ear_dir_y <= r.ey; ear_dir_z <= r.ez;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        pair_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_pairs.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result %0d %0d", left_out, right_out);
                end
                else
                begin
                    want = expected_pairs.pop_front();
                    if (want.lo !== left_out || want.ro !== right_out)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %0d %0d, got %0d %0d",
                                want.lo, want.ro, left_out, right_out);
                    end
                end
            end
            if (recv_gap > 0)
            begin
                recv_gap--;
                out_stall <= 1'b1;
            end
            else if (!quiet_tail && $urandom_range(0, 15) == 0)
            begin
                recv_gap = $urandom_range(0, 11);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    initial
    begin
        wait (fill_done && rst_n);
        @(posedge clk);
        while (pending_q.size() > 0 || in_valid || expected_pairs.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 20) @(posedge clk);
        if (mismatches == 0 && expected_pairs.size() == 0)
            $display("tb_distance_attenuate_and_pan: clean");
        else
            $display("tb_distance_attenuate_and_pan: errors");
        $finish;
    end

    initial
    begin
        #200000;
        $display("tb_distance_attenuate_and_pan: errors");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/dap_pkg.sv
rtl/dap_front.sv
rtl/dap_root.sv
rtl/dap_div.sv
rtl/dap_scale.sv
rtl/distance_attenuate_and_pan.sv
rtl/dap_checker.sv
tb/sv/tb_distance_attenuate_and_pan.sv
